// ===== hw/rtl/pfba_pkg.sv =====
// Shared types and constants of the page frame bitmap allocator.
`default_nettype none

package pfba_pkg;

  // bitmap is stored as words of this many frames
  localparam int WORD_BITS = 32;
  localparam int WB_W      = $clog2(WORD_BITS);
  localparam int POP_W     = WB_W + 1;

  localparam int MAX_FRAMES_DEF = 1024;

  // fixed field widths
  localparam int OP_W       = 3;
  localparam int FRAME_W    = 10;
  localparam int END_W      = 11;
  localparam int STATUS_W   = 3;
  localparam int FREE_W     = 11;
  localparam int PAGES_W    = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int IN_W       = OP_W + FRAME_W + END_W;
  localparam int OUT_W      = STATUS_W + FRAME_W + FREE_W;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 3'd0,
    OP_TOP   = 3'd1,
    OP_FREE  = 3'd2,
    OP_MARK  = 3'd3,
    OP_COUNT = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_NONE_FREE    = 3'd1,
    ST_TOP_USED     = 3'd2,
    ST_ALREADY_FREE = 3'd3,
    ST_OUT_OF_RANGE = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAGES    = 2'd0,
    CFG_PAGING   = 2'd1,
    CFG_RESERVED = 2'd2,
    CFG_TOP      = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_HOLD
  } state_t;

  // per-word result flags from the word unit
  typedef struct packed {
    logic            alloc_hit;
    logic [WB_W-1:0] alloc_bit;
    logic            tgt_hit;
    logic            tgt_busy;
  } wres_t;

  // undefined codes behave like a count request
  function automatic op_t decode_op(input logic [OP_W-1:0] code);
    op_t op;
    case (code)
      3'd0:    op = OP_ALLOC;
      3'd1:    op = OP_TOP;
      3'd2:    op = OP_FREE;
      3'd3:    op = OP_MARK;
      default: op = OP_COUNT;
    endcase
    return op;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pfba_word_unit.sv =====
// Shared word unit: updates one bitmap word for the current request and counts it.
`default_nettype none

module pfba_word_unit #(
  parameter int XW   = 11,
  parameter int WIDX = 5
) (
  input  wire pfba_pkg::op_t                   op,
  input  wire logic [WIDX-1:0]                 word_idx,
  input  wire logic [pfba_pkg::WORD_BITS-1:0]  rdata,
  input  wire logic [XW-1:0]                   n,
  input  wire logic [XW-1:0]                   start,
  input  wire logic [XW-1:0]                   lo,
  input  wire logic [XW-1:0]                   hi,
  input  wire logic [XW-1:0]                   tgt,
  input  wire logic                            alloc_en,
  output logic      [pfba_pkg::WORD_BITS-1:0]  wdata,
  output logic                                 we,
  output logic      [pfba_pkg::POP_W-1:0]      pop,
  output pfba_pkg::wres_t                      res
);
  import pfba_pkg::*;

  localparam int HW = XW - WB_W;
  localparam logic [WORD_BITS-1:0] ONES = '1;

  // bits of word w whose frame index is below lim
  function automatic logic [WORD_BITS-1:0] lt_mask(input logic [WIDX-1:0] w,
                                                    input logic [XW-1:0] lim);
    logic [HW-1:0] wx;
    logic [WORD_BITS-1:0] m;
    wx = HW'(w);
    if (wx < lim[XW-1:WB_W]) begin
      m = ONES;
    end else if (wx == lim[XW-1:WB_W]) begin
      m = ~(ONES << lim[WB_W-1:0]);
    end else begin
      m = '0;
    end
    return m;
  endfunction

  logic [WORD_BITS-1:0] valid;
  logic [WORD_BITS-1:0] cand;
  logic [WORD_BITS-1:0] tmask;
  logic [WORD_BITS-1:0] span;
  logic [WB_W-1:0]      low_bit;

  always_comb begin
    valid = lt_mask(word_idx, n);
    cand  = ~rdata & valid & ~lt_mask(word_idx, start);
    span  = ~lt_mask(word_idx, lo) & lt_mask(word_idx, hi) & valid;
    tmask = (HW'(word_idx) == tgt[XW-1:WB_W]) ?
            ((WORD_BITS)'(1) << tgt[WB_W-1:0]) & valid : '0;
    low_bit = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        low_bit = WB_W'(i);
      end
    end
  end

  always_comb begin
    wdata         = rdata;
    res.alloc_hit = 1'b0;
    res.alloc_bit = low_bit;
    res.tgt_hit   = |tmask;
    res.tgt_busy  = |(rdata & tmask);
    case (op)
      OP_ALLOC: begin
        if (alloc_en && (|cand)) begin
          res.alloc_hit = 1'b1;
          wdata = rdata | ((WORD_BITS)'(1) << low_bit);
        end
      end
      OP_TOP: begin
        if (res.tgt_hit && !res.tgt_busy) begin
          wdata = rdata | tmask;
        end
      end
      OP_FREE: begin
        if (res.tgt_busy) begin
          wdata = rdata & ~tmask;
        end
      end
      OP_MARK: wdata = rdata | span;
      default: wdata = rdata;
    endcase
    we  = (wdata != rdata);
    pop = POP_W'($countones(wdata & valid));
  end

endmodule

`default_nettype wire

// ===== hw/rtl/page_frame_bitmap_allocator.sv =====
// Top level of the page frame bitmap allocator: sequencer, bitmap memory, config, output.
`default_nettype none

// Channel   Dir  Width  Contents
// s_axis    in   24     request: operation [2:0], frame [12:3], range_end [23:13]
// m_axis    out  24     result: status [2:0], granted_frame [12:3], free_frames [23:13]
// cfg       in   2+11   write enable, register index, write data (no read-back)
//
// Every request takes one sweep over the bitmap words, NW = ceil(MAX_FRAMES / 32): each word
// is read into rdata, updated by the word unit and written back if it changed; after the
// last word the sequencer holds the result until the output register takes it, and only then
// takes the next request. The sweep is bound by the single read port of the bitmap memory and
// the one shared word unit.
// After reset the bitmap is cleared one word per cycle before the first
// request is taken; config writes are taken throughout.
// A finished result waits in the output register while the next request is taken; a
// second result waits in the sequencer until the output register frees up.

module page_frame_bitmap_allocator #(
  parameter int MAX_FRAMES = pfba_pkg::MAX_FRAMES_DEF
) (
  input  wire                                clk,
  input  wire                                rst,
  // operation, frame, range_end (from bit 0 up)
  input  wire  [pfba_pkg::IN_W-1:0]          s_axis_tdata,
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  // status, granted_frame, free_frames (from bit 0 up)
  output logic [pfba_pkg::OUT_W-1:0]         m_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  input  wire                                cfg_we,
  input  wire  [pfba_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [pfba_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import pfba_pkg::*;

  localparam int NW    = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int WIDX  = (NW > 1) ? $clog2(NW) : 1;
  localparam int PW    = $clog2(MAX_FRAMES + 1);
  localparam int XW_A  = (PW > WIDX + WB_W) ? PW : WIDX + WB_W;
  localparam int XW    = (XW_A > PAGES_W) ? XW_A : PAGES_W;
  localparam logic [WIDX-1:0] LAST_WORD = WIDX'(NW - 1);
  localparam logic [XW-1:0]   MAX_X     = XW'(MAX_FRAMES);

  // ---------------- configuration registers ----------------
  logic [PAGES_W-1:0] pages_in_use;
  logic               paging_enabled;
  logic [FRAME_W-1:0] reserved_low_frames;
  logic [FRAME_W-1:0] top_frame;

  always_ff @(posedge clk) begin
    if (rst) begin
      pages_in_use        <= PAGES_W'(1024);
      paging_enabled      <= 1'b0;
      reserved_low_frames <= FRAME_W'(16);
      top_frame           <= FRAME_W'(1023);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PAGES:    pages_in_use        <= cfg_data[PAGES_W-1:0];
        CFG_PAGING:   paging_enabled      <= cfg_data[0];
        CFG_RESERVED: reserved_low_frames <= cfg_data[FRAME_W-1:0];
        CFG_TOP:      top_frame           <= cfg_data[FRAME_W-1:0];
        default:      ;
      endcase
    end
  end

  // frames present, clamped to the bitmap size
  logic [XW-1:0] pages_x;
  logic [XW-1:0] n;
  logic [XW-1:0] start;
  assign pages_x = XW'(pages_in_use);
  assign n       = (pages_x > MAX_X) ? MAX_X : pages_x;
  assign start   = paging_enabled ? '0 : XW'(reserved_low_frames);

  // ---------------- request fields ----------------
  op_t           in_op;
  logic [XW-1:0] in_frame;
  logic [XW-1:0] in_end;
  assign in_op    = decode_op(s_axis_tdata[OP_W-1:0]);
  assign in_frame = XW'(s_axis_tdata[OP_W +: FRAME_W]);
  assign in_end   = XW'(s_axis_tdata[OP_W + FRAME_W +: END_W]);

  // ---------------- sequencer state ----------------
  state_t          state;
  state_t          state_next;
  logic [WIDX-1:0] clr_idx;
  logic [WIDX-1:0] rd_idx;
  logic            issue_on;
  logic            proc_valid;
  logic [WIDX-1:0] proc_idx;
  op_t             op_r;
  logic [XW-1:0]   lo_r;
  logic [XW-1:0]   hi_r;
  logic [XW-1:0]   tgt_r;
  logic            found;
  logic [XW-1:0]   grant;
  logic [XW-1:0]   used;
  status_t         status_r;

  logic            accept;
  logic            clr_mode;
  logic            scan_last;
  logic            out_load;

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign scan_last = proc_valid && (proc_idx == LAST_WORD);

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr_idx == LAST_WORD) state_next = S_IDLE;
      S_IDLE:  if (s_axis_tvalid) state_next = S_SCAN;
      S_SCAN:  if (scan_last) state_next = S_HOLD;
      S_HOLD:  if (!m_axis_tvalid || m_axis_tready) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    s_axis_tready = (state == S_IDLE);
    clr_mode      = (state == S_CLEAR);
    out_load      = (state == S_HOLD) && (!m_axis_tvalid || m_axis_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // ---------------- bitmap memory ----------------
  logic [WORD_BITS-1:0] mem [NW];
  logic [WORD_BITS-1:0] rdata;
  logic [WORD_BITS-1:0] wdata;
  logic                 wu_we;
  logic [POP_W-1:0]     pop;
  wres_t                wres;

  always_ff @(posedge clk) begin
    if (clr_mode) begin
      mem[clr_idx] <= '0;
    end else if (proc_valid && wu_we) begin
      mem[proc_idx] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (clr_mode && clr_idx != LAST_WORD) begin
      clr_idx <= clr_idx + WIDX'(1);
    end
  end

  pfba_word_unit #(
    .XW   (XW),
    .WIDX (WIDX)
  ) u_word (
    .op       (op_r),
    .word_idx (proc_idx),
    .rdata    (rdata),
    .n        (n),
    .start    (start),
    .lo       (lo_r),
    .hi       (hi_r),
    .tgt      (tgt_r),
    .alloc_en (!found),
    .wdata    (wdata),
    .we       (wu_we),
    .pop      (pop),
    .res      (wres)
  );

  // ---------------- sweep ----------------
  logic [XW-1:0] used_sum;
  assign used_sum = used + XW'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      issue_on   <= 1'b0;
      proc_valid <= 1'b0;
    end else begin
      proc_valid <= issue_on;
      if (accept) begin
        issue_on <= 1'b1;
      end else if (issue_on && rd_idx == LAST_WORD) begin
        issue_on <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    proc_idx <= rd_idx;
    if (accept) begin
      rd_idx <= '0;
    end else if (issue_on && rd_idx != LAST_WORD) begin
      rd_idx <= rd_idx + WIDX'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_op;
      lo_r     <= in_frame;
      hi_r     <= in_end;
      tgt_r    <= (in_op == OP_TOP) ? XW'(top_frame) : in_frame;
      found    <= 1'b0;
      grant    <= '0;
      used     <= '0;
      status_r <= ST_OK;
      // single-frame requests past the frames present change nothing
      if ((in_op == OP_TOP && XW'(top_frame) >= n) ||
          (in_op == OP_FREE && in_frame >= n)) begin
        status_r <= ST_OUT_OF_RANGE;
      end
    end else if (proc_valid) begin
      used <= used_sum;
      if (wres.alloc_hit) begin
        found <= 1'b1;
        grant <= XW'({proc_idx, wres.alloc_bit});
      end
      if (op_r == OP_TOP && wres.tgt_hit) begin
        if (wres.tgt_busy) begin
          status_r <= ST_TOP_USED;
        end else begin
          grant <= tgt_r;
        end
      end
      if (op_r == OP_FREE && wres.tgt_hit && !wres.tgt_busy) begin
        status_r <= ST_ALREADY_FREE;
      end
      if (scan_last && op_r == OP_ALLOC && !found && !wres.alloc_hit) begin
        status_r <= ST_NONE_FREE;
      end
    end
  end

  // ---------------- result register ----------------
  logic [XW-1:0] free_x;
  assign free_x = n - used;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {free_x[FREE_W-1:0], grant[FRAME_W-1:0], status_r};
    end
  end

endmodule

`default_nettype wire

// ===== dv/page_frame_bitmap_allocator_checker.sv =====
// Checker for the page frame bitmap allocator: bitmap predictor and result comparison.
`timescale 1ns / 1ps

module page_frame_bitmap_allocator_checker #(
  parameter int MAX_FRAMES = pfba_pkg::MAX_FRAMES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [pfba_pkg::IN_W-1:0]       s_axis_tdata,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [pfba_pkg::OUT_W-1:0]      m_axis_tdata,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic                            cfg_we,
  input  logic [pfba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pfba_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              mismatches,
  output int                              outstanding
);
  import pfba_pkg::*;

  // same layout as m_axis_tdata: status in the low bits
  typedef struct packed {
    logic [FREE_W-1:0]  free_frames;
    logic [FRAME_W-1:0] granted_frame;
    status_t            status;
  } alloc_result_t;

  bit [MAX_FRAMES-1:0] occupied;
  logic [PAGES_W-1:0]  pages_in_use;
  logic                paging_on;
  logic [FRAME_W-1:0]  reserved_low;
  logic [FRAME_W-1:0]  top_frame;
  alloc_result_t       pending_results[$];

  initial mismatches  = 0;
  initial outstanding = 0;

  // Applies one request to the bitmap and works out its result.
  function automatic alloc_result_t apply_request(input logic [IN_W-1:0] req);
    logic [OP_W-1:0] code;
    int              fr;
    int              stop;
    int              n;
    int              start;
    int              used;
    int              i;
    bit              found;
    alloc_result_t   r;
    code = req[OP_W-1:0];
    fr   = req[OP_W +: FRAME_W];
    stop = req[OP_W+FRAME_W +: END_W];
    n    = (pages_in_use > MAX_FRAMES) ? MAX_FRAMES : pages_in_use;
    r.status        = ST_OK;
    r.granted_frame = '0;
    case (code)
      OP_ALLOC: begin
        start = paging_on ? 0 : int'(reserved_low);
        found = 1'b0;
        for (i = start; i < n; i++) begin
          if (!occupied[i]) begin
            occupied[i]     = 1'b1;
            r.granted_frame = FRAME_W'(i);
            found           = 1'b1;
            break;
          end
        end
        if (!found) r.status = ST_NONE_FREE;
      end
      OP_TOP: begin
        if (top_frame >= n) r.status = ST_OUT_OF_RANGE;
        else if (occupied[top_frame]) r.status = ST_TOP_USED;
        else begin
          occupied[top_frame] = 1'b1;
          r.granted_frame     = top_frame;
        end
      end
      OP_FREE: begin
        if (fr >= n) r.status = ST_OUT_OF_RANGE;
        else if (!occupied[fr]) r.status = ST_ALREADY_FREE;
        else occupied[fr] = 1'b0;
      end
      OP_MARK: begin
        if (stop > n) stop = n;
        for (i = fr; i < stop; i++) occupied[i] = 1'b1;
      end
      default: ;
    endcase
    used = 0;
    for (i = 0; i < n; i++) if (occupied[i]) used++;
    r.free_frames = FREE_W'(n - used);
    return r;
  endfunction

  always @(posedge clk) begin
    alloc_result_t got;
    alloc_result_t want;
    if (rst) begin
      occupied     = '0;
      pages_in_use = PAGES_W'(MAX_FRAMES_DEF);
      paging_on    = 1'b0;
      reserved_low = FRAME_W'(16);
      top_frame    = FRAME_W'(MAX_FRAMES_DEF - 1);
      pending_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PAGES:    pages_in_use = cfg_data[PAGES_W-1:0];
          CFG_PAGING:   paging_on    = cfg_data[0];
          CFG_RESERVED: reserved_low = cfg_data[FRAME_W-1:0];
          CFG_TOP:      top_frame    = cfg_data[FRAME_W-1:0];
          default: ;
        endcase
      end
      // results first, so a same-edge request never matches its own result
      if (m_axis_tvalid && m_axis_tready) begin
        got = alloc_result_t'(m_axis_tdata);
        if (pending_results.size() == 0) begin
          $error("result with no request outstanding: %h", m_axis_tdata);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatches++;
          end
          if (got.granted_frame !== want.granted_frame) begin
            $error("granted_frame: expected %0d, got %0d", want.granted_frame,
                   got.granted_frame);
            mismatches++;
          end
          if (got.free_frames !== want.free_frames) begin
            $error("free_frames: expected %0d, got %0d", want.free_frames,
                   got.free_frames);
            mismatches++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) pending_results.push_back(apply_request(s_axis_tdata));
    end
    outstanding <= pending_results.size();
  end

endmodule

// ===== dv/page_frame_bitmap_allocator_tb.sv =====
// Testbench top of the page frame bitmap allocator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module page_frame_bitmap_allocator_tb;
  import pfba_pkg::*;

  localparam int RANDOM_REQUESTS = 1650;
  localparam int PHASES          = 10;
  // no accepted request or result for this long means the block hung
  localparam int WATCHDOG_CYCLES = 4000;
  // a little more than one full sweep over the bitmap words
  localparam int DRAIN_CYCLES    = 40;
  localparam int FRAME_SPAN      = 1 << FRAME_W;
  localparam int END_SPAN        = 1 << END_W;
  localparam int MAX_GAP         = 17;

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic [IN_W-1:0]       s_axis_tdata  = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [OUT_W-1:0]      m_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic                  cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index     = CFG_PAGES;
  logic [CFG_DATA_W-1:0] cfg_data      = '0;

  int mismatches;
  int outstanding;
  int idle_cycles = 0;

  // steady stretches: while set, that side never idles
  bit snd_steady = 1'b0;
  bit rcv_steady = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  page_frame_bitmap_allocator dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  page_frame_bitmap_allocator_checker alloc_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  // Watchdog: covers the clearing pass, a full sweep and both sides' longest gaps
  // many times over.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result side: random stall before each result, with steady stretches.
  initial begin
    int stall;
    wait (!rst);
    forever begin
      if ($urandom_range(0, 39) == 0) rcv_steady = !rcv_steady;
      stall = rcv_steady ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  // Send one request after a random gap; returns at the accepting edge with
  // tvalid still high, so back-to-back requests never drop it.
  task automatic issue(input logic [OP_W-1:0] code, input int fr, input int stop);
    int gap;
    if ($urandom_range(0, 39) == 0) snd_steady = !snd_steady;
    gap = snd_steady ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tdata  <= {END_W'(stop), FRAME_W'(fr), code};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Drop tvalid, wait for every result, then let the sequencer settle.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all four registers on consecutive edges; only called while idle.
  task automatic program_regs(input int pages, input int paging, input int reserved,
                              input int top);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PAGES;
    cfg_data  <= CFG_DATA_W'(pages);
    @(posedge clk);
    cfg_index <= CFG_PAGING;
    cfg_data  <= CFG_DATA_W'(paging);
    @(posedge clk);
    cfg_index <= CFG_RESERVED;
    cfg_data  <= CFG_DATA_W'(reserved);
    @(posedge clk);
    cfg_index <= CFG_TOP;
    cfg_data  <= CFG_DATA_W'(top);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int c;
    int p;
    int k;
    int pages;
    int lim;
    int paging;
    int reserved;
    int top;
    int start;
    int sel;
    int fr;
    int stop;
    int per_phase;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // ---------------- directed part ----------------
    // Reset config: 1024 frames, paging off, 16 reserved, top frame 1023.
    issue(OP_COUNT, 0, 0);
    issue(OP_ALLOC, FRAME_SPAN - 1, END_SPAN - 1);   // first frame above the reserved ones
    issue(OP_ALLOC, 0, 0);
    issue(OP_TOP, 0, 0);                             // claims the top frame
    issue(OP_TOP, 0, 0);                             // top already used
    issue(OP_FREE, 16, 0);
    issue(OP_FREE, 16, 0);                           // double free
    issue(OP_MARK, 5, 3);                            // empty span still reports ok
    issue(OP_MARK, 1000, 1024);
    issue(OP_MARK, 0, END_SPAN - 1);                 // end clamps, whole bitmap taken
    issue(OP_ALLOC, 0, 0);                           // nothing free
    issue(OP_FREE, 0, 0);
    issue(OP_FREE, FRAME_SPAN - 1, 0);
    issue(OP_ALLOC, 0, 0);                           // frame 0 free but below the search start
    for (c = int'(OP_COUNT) + 1; c < (1 << OP_W); c++)
      issue(OP_W'(c), FRAME_SPAN - 1, END_SPAN - 1); // undefined codes act as count

    // No frames at all.
    wait_idle();
    program_regs(0, 0, 16, FRAME_SPAN - 1);
    issue(OP_ALLOC, 0, 0);
    issue(OP_TOP, 0, 0);
    issue(OP_FREE, 0, 0);

    // Page count above the bitmap size, search from frame zero, top at zero.
    wait_idle();
    program_regs(END_SPAN - 1, 1, FRAME_SPAN - 1, 0);
    issue(OP_ALLOC, 0, 0);                           // gets frame 0
    issue(OP_TOP, 0, 0);                             // frame 0 now used

    // Search start and top frame both beyond the frames present.
    wait_idle();
    program_regs(100, 0, 200, 500);
    issue(OP_ALLOC, 0, 0);
    issue(OP_TOP, 0, 0);
    issue(OP_FREE, 700, 0);
    issue(OP_MARK, 0, END_SPAN - 1);

    // ---------------- random part ----------------
    per_phase = RANDOM_REQUESTS / PHASES;
    for (p = 0; p < PHASES; p++) begin
      // small page counts in about half the phases so the bitmap fills, empties and overflows often
      k = $urandom_range(0, 5);
      case (k)
        0:       pages = 1;
        1:       pages = END_SPAN - 1;
        2:       pages = FRAME_SPAN;
        5:       pages = $urandom_range(1, END_SPAN - 1);
        default: pages = $urandom_range(1, 96);
      endcase
      paging   = $urandom_range(0, 1);
      reserved = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 48)
                                              : $urandom_range(0, FRAME_SPAN - 1);
      lim = (pages > FRAME_SPAN) ? FRAME_SPAN : pages;
      top = ($urandom_range(0, 3) != 0) ? $urandom_range(0, lim - 1)
                                         : $urandom_range(0, FRAME_SPAN - 1);
      // first two phases pin the register extremes
      if (p == 0) begin
        pages    = 1;
        paging   = 1;
        reserved = 0;
        top      = 0;
      end else if (p == 1) begin
        pages    = END_SPAN - 1;
        paging   = 0;
        reserved = FRAME_SPAN - 1;
        top      = FRAME_SPAN - 1;
      end
      wait_idle();
      program_regs(pages, paging, reserved, top);
      start = paging ? 0 : reserved;

      repeat (per_phase) begin
        sel  = $urandom_range(0, 99);
        // fields a request ignores still carry random bits
        fr   = $urandom_range(0, FRAME_SPAN - 1);
        stop = $urandom_range(0, END_SPAN - 1);
        if (sel < 30) begin
          issue(OP_ALLOC, fr, stop);
        end else if (sel < 38) begin
          issue(OP_TOP, fr, stop);
        end else if (sel < 68) begin
          // allocations pack upward from the search start, so aim frees there
          if ($urandom_range(0, 3) != 0) fr = (start + $urandom_range(0, 63)) % FRAME_SPAN;
          issue(OP_FREE, fr, stop);
        end else if (sel < 83) begin
          if ($urandom_range(0, 1) != 0) fr = (start + $urandom_range(0, 63)) % FRAME_SPAN;
          if ($urandom_range(0, 4) != 0) stop = fr + $urandom_range(0, 24);
          issue(OP_MARK, fr, stop);
        end else if (sel < 93) begin
          issue(OP_COUNT, fr, stop);
        end else begin
          issue(OP_W'($urandom_range(int'(OP_COUNT) + 1, (1 << OP_W) - 1)), fr, stop);
        end
      end
    end

    wait_idle();
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
